FILE: rtl/dpp_pkg.sv
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared types, constants and decode helpers for the DHCP packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dpp_pkg;

  localparam int unsigned CountW = 11;
  localparam logic [CountW-1:0] MaxPacketBytes = 11'd2047;

  localparam logic [CountW-1:0] ChaddrAt  = 11'd28;
  localparam logic [CountW-1:0] SnameAt   = 11'd44;
  localparam logic [CountW-1:0] FileAt    = 11'd108;
  localparam logic [CountW-1:0] AreaEnd   = 11'd236;
  localparam logic [CountW-1:0] CookieLast = 11'd239;
  localparam logic [CountW-1:0] CookieEnd = 11'd240;

  localparam logic [7:0] OptPad = 8'd0;
  localparam logic [7:0] OptEnd = 8'd255;

  localparam logic [10:0] MinLenReset = 11'd240;
  localparam logic [31:0] CookieReset = 32'h6382_5363;

  localparam logic [1:0] CfgMinLen = 2'd0;
  localparam logic [1:0] CfgCookie = 2'd1;

  localparam logic [2:0] KindField    = 3'd0;
  localparam logic [2:0] KindAreaByte = 3'd1;
  localparam logic [2:0] KindOptHdr   = 3'd2;
  localparam logic [2:0] KindOptByte  = 3'd3;
  localparam logic [2:0] KindStatus   = 3'd4;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StTooShort  = 3'd1;
  localparam logic [2:0] StBadCookie = 3'd2;
  localparam logic [2:0] StNoLength  = 3'd3;
  localparam logic [2:0] StTruncated = 3'd4;

  localparam logic [3:0] IdChaddr = 4'd11;
  localparam logic [3:0] IdSname  = 4'd12;
  localparam logic [3:0] IdFile   = 4'd13;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;

  typedef enum logic [4:0] {
    PH_FIXED = 5'b00001,
    PH_CODE  = 5'b00010,
    PH_LEN   = 5'b00100,
    PH_VALUE = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_e;

  // One queue entry: an optional byte result and an optional final status.
  typedef struct packed {
    logic        has_a;
    logic [2:0]  kind;
    logic [3:0]  field_id;
    logic [31:0] field_value;
    logic [7:0]  option_code;
    logic [7:0]  byte_offset;
    logic        has_st;
    logic [2:0]  status;
  } entry_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  id;
    logic [31:0] mask;
  } hdr_end_t;

  function automatic hdr_end_t hdr_field_end(input logic [4:0] p);
    hdr_end_t r;
    r = '{valid: 1'b1, id: 4'd0, mask: 32'hFFFF_FFFF};
    unique case (p)
      5'd0:  r = '{valid: 1'b1, id: 4'd0,  mask: 32'h0000_00FF};
      5'd1:  r = '{valid: 1'b1, id: 4'd1,  mask: 32'h0000_00FF};
      5'd2:  r = '{valid: 1'b1, id: 4'd2,  mask: 32'h0000_00FF};
      5'd3:  r = '{valid: 1'b1, id: 4'd3,  mask: 32'h0000_00FF};
      5'd7:  r = '{valid: 1'b1, id: 4'd4,  mask: 32'hFFFF_FFFF};
      5'd9:  r = '{valid: 1'b1, id: 4'd5,  mask: 32'h0000_FFFF};
      5'd11: r = '{valid: 1'b1, id: 4'd6,  mask: 32'h0000_FFFF};
      5'd15: r = '{valid: 1'b1, id: 4'd7,  mask: 32'hFFFF_FFFF};
      5'd19: r = '{valid: 1'b1, id: 4'd8,  mask: 32'hFFFF_FFFF};
      5'd23: r = '{valid: 1'b1, id: 4'd9,  mask: 32'hFFFF_FFFF};
      5'd27: r = '{valid: 1'b1, id: 4'd10, mask: 32'hFFFF_FFFF};
      default: r = '{valid: 1'b0, id: 4'd0, mask: 32'h0000_0000};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dpp_front.sv
// ----------------------------------------------------------------------------
// dpp_front
// Byte-level parse state: accepts packet bytes, classifies them and builds
// one queue entry per byte that produces results.
// ----------------------------------------------------------------------------
`default_nettype none

module dpp_front import dpp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [10:0] min_len_i,
  input  wire logic [31:0] cookie_i,
  output      logic        wr_en_o,
  output      entry_t      wr_entry_o
);

  logic [CountW-1:0] cnt_q, cnt_d;
  phase_e            phase_q, phase_d;
  logic [31:0]       acc_q, acc_d;
  logic [7:0]        code_q, code_d;
  logic [7:0]        left_q, left_d;
  logic [7:0]        off_q, off_d;
  logic              bad_q, bad_d;
  entry_t            ent;
  hdr_end_t          hf;
  logic [CountW-1:0] area_off;

  always_comb begin
    cnt_d   = (cnt_q == MaxPacketBytes) ? cnt_q : cnt_q + 11'd1;
    phase_d = phase_q;
    acc_d   = acc_q;
    code_d  = code_q;
    left_d  = left_q;
    off_d   = off_q;
    bad_d   = bad_q;
    ent     = '0;
    hf      = hdr_field_end(cnt_q[4:0]);
    area_off = '0;

    unique case (phase_q)
      PH_FIXED: begin
        acc_d = {acc_q[23:0], data_byte_i};
        if (cnt_q < ChaddrAt) begin
          if (hf.valid) begin
            ent.has_a       = 1'b1;
            ent.kind        = KindField;
            ent.field_id    = hf.id;
            ent.field_value = acc_d & hf.mask;
          end
        end else if (cnt_q < AreaEnd) begin
          ent.has_a       = 1'b1;
          ent.kind        = KindAreaByte;
          ent.field_value = {24'd0, data_byte_i};
          if (cnt_q < SnameAt) begin
            ent.field_id = IdChaddr;
            area_off     = cnt_q - ChaddrAt;
          end else if (cnt_q < FileAt) begin
            ent.field_id = IdSname;
            area_off     = cnt_q - SnameAt;
          end else begin
            ent.field_id = IdFile;
            area_off     = cnt_q - FileAt;
          end
          ent.byte_offset = area_off[7:0];
        end else if (cnt_q == CookieLast) begin
          if (acc_d != cookie_i) begin
            bad_d   = 1'b1;
            phase_d = PH_DONE;
          end else begin
            phase_d = PH_CODE;
          end
        end
      end
      PH_CODE: begin
        if (data_byte_i == OptEnd) begin
          phase_d = PH_DONE;
        end else if (data_byte_i != OptPad) begin
          code_d  = data_byte_i;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        ent.has_a       = 1'b1;
        ent.kind        = KindOptHdr;
        ent.field_value = {24'd0, data_byte_i};
        ent.option_code = code_q;
        left_d  = data_byte_i;
        off_d   = 8'd0;
        phase_d = (data_byte_i == 8'd0) ? PH_CODE : PH_VALUE;
      end
      PH_VALUE: begin
        ent.has_a       = 1'b1;
        ent.kind        = KindOptByte;
        ent.field_value = {24'd0, data_byte_i};
        ent.option_code = code_q;
        ent.byte_offset = off_q;
        off_d  = off_q + 8'd1;
        left_d = left_q - 8'd1;
        if (left_d == 8'd0) begin
          phase_d = PH_CODE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (last_byte_i) begin
      ent.has_st = 1'b1;
      if (cnt_d < CookieEnd || cnt_d < min_len_i) begin
        ent.status = StTooShort;
      end else if (bad_d) begin
        ent.status = StBadCookie;
      end else if (phase_d == PH_LEN) begin
        ent.status = StNoLength;
      end else if (phase_d == PH_VALUE && left_d != 8'd0) begin
        ent.status = StTruncated;
      end else begin
        ent.status = StOk;
      end
      cnt_d   = '0;
      phase_d = PH_FIXED;
      acc_d   = '0;
      code_d  = '0;
      left_d  = '0;
      off_d   = '0;
      bad_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= PH_FIXED;
      acc_q   <= '0;
      code_q  <= '0;
      left_q  <= '0;
      off_q   <= '0;
      bad_q   <= 1'b0;
    end else if (accept_i) begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
      acc_q   <= acc_d;
      code_q  <= code_d;
      left_q  <= left_d;
      off_q   <= off_d;
      bad_q   <= bad_d;
    end
  end

  assign wr_en_o    = accept_i && (ent.has_a || ent.has_st);
  assign wr_entry_o = ent;

endmodule

`default_nettype wire

FILE: rtl/dpp_queue.sv
// ----------------------------------------------------------------------------
// dpp_queue
// Short entry queue between the parse front and the result back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dpp_queue import dpp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   wr_en_i,
  input  wire entry_t wr_entry_i,
  input  wire logic   rd_en_i,
  output      entry_t rd_entry_o,
  output      logic   full_o,
  output      logic   empty_o
);

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + (QPtrW+1)'(1);
      end else if (rd_en_i && !wr_en_i) begin
        cnt_q <= cnt_q - (QPtrW+1)'(1);
      end
    end
  end

  assign rd_entry_o = mem_q[rd_ptr_q];
  assign full_o     = (cnt_q == (QPtrW+1)'(QDepth));
  assign empty_o    = (cnt_q == '0);

endmodule

`default_nettype wire

FILE: rtl/dpp_back.sv
// ----------------------------------------------------------------------------
// dpp_back
// Result back end: unpacks the head entry into one or two results and
// retires the entry once its last result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module dpp_back import dpp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire entry_t      head_i,
  input  wire logic        q_empty_i,
  input  wire logic        pop_i,
  output      logic        rd_en_o,
  output      logic [2:0]  kind_o,
  output      logic [3:0]  field_id_o,
  output      logic [31:0] field_value_o,
  output      logic [7:0]  option_code_o,
  output      logic [7:0]  byte_offset_o,
  output      logic [2:0]  status_o,
  output      logic        last_result_o
);

  logic sel_q;
  logic show_a;
  logic entry_done;
  logic take;

  assign show_a     = head_i.has_a && !sel_q;
  assign entry_done = !show_a || !head_i.has_st;
  assign take       = pop_i && !q_empty_i;
  assign rd_en_o    = take && entry_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (take) begin
      sel_q <= !entry_done;
    end
  end

  always_comb begin
    if (show_a) begin
      kind_o        = head_i.kind;
      field_id_o    = head_i.field_id;
      field_value_o = head_i.field_value;
      option_code_o = head_i.option_code;
      byte_offset_o = head_i.byte_offset;
      status_o      = StOk;
      last_result_o = !head_i.has_st;
    end else begin
      kind_o        = KindStatus;
      field_id_o    = '0;
      field_value_o = '0;
      option_code_o = '0;
      byte_offset_o = '0;
      status_o      = head_i.status;
      last_result_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dhcp_packet_parser_core.sv
// ----------------------------------------------------------------------------
// dhcp_packet_parser_core
// DHCP/BOOTP packet parser: header fields, header area bytes, options and a
// final status per packet, one packet byte per transaction.
// ----------------------------------------------------------------------------
//  channel   | handshake                    | payload
//  ----------+------------------------------+---------------------------------
//  bytes in  | push / full                  | data_byte_i, last_byte_i
//  results   | pop / empty                  | kind_o .. last_result_o
//  config    | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
//  One byte is accepted per cycle while full is low; its state update completes
//  in that cycle. A byte yields up to two results, drained one per cycle from a
//  4-entry queue while pop is held and empty is low. full rises when the queue
//  holds four pending entries, so a withheld pop fills the queue and then stalls
//  the input. Reset returns to the header phase with default configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module dhcp_packet_parser_core import dpp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [2:0]  kind_o,
  output      logic [3:0]  field_id_o,
  output      logic [31:0] field_value_o,
  output      logic [7:0]  option_code_o,
  output      logic [7:0]  byte_offset_o,
  output      logic [2:0]  status_o,
  output      logic        last_result_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [10:0] min_len_q;
  logic [31:0] cookie_q;
  logic        accept;
  logic        wr_en;
  entry_t      wr_entry;
  logic        rd_en;
  entry_t      head;
  logic        q_full;
  logic        q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenReset;
      cookie_q  <= CookieReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMinLen: min_len_q <= cfg_data_i[10:0];
        CfgCookie: cookie_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign full   = q_full;
  assign empty  = q_empty;
  assign accept = push && !q_full;

  dpp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .min_len_i  (min_len_q),
    .cookie_i   (cookie_q),
    .wr_en_o    (wr_en),
    .wr_entry_o (wr_entry)
  );

  dpp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_entry_i(wr_entry),
    .rd_en_i   (rd_en),
    .rd_entry_o(head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  dpp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_empty_i    (q_empty),
    .pop_i        (pop),
    .rd_en_o      (rd_en),
    .kind_o       (kind_o),
    .field_id_o   (field_id_o),
    .field_value_o(field_value_o),
    .option_code_o(option_code_o),
    .byte_offset_o(byte_offset_o),
    .status_o     (status_o),
    .last_result_o(last_result_o)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for dhcp_packet_parser_core. Packets are pushed one byte
// per transaction and every popped result is compared, in order, with the
// results predicted from the bytes and register values already accepted. A
// directed table of packets covers the extremes and every final status;
// random packets, register settings and idling on both sides follow.
// ----------------------------------------------------------------------------
module testbench;
  import dpp_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned RandItems    = 1450;
  localparam int unsigned IdleSettle   = 8;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned RxHoldCycles = 500;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned NumSegs      = 43;

  localparam logic [1:0] CfgSpare = 2'd2;

  localparam int unsigned GapNone = 0;
  localparam int unsigned GapAny  = 1;
  localparam int unsigned GapRare = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  field_id;
    logic [31:0] field_value;
    logic [7:0]  option_code;
    logic [7:0]  byte_offset;
    logic [2:0]  status;
    logic        last_result;
  } parse_result_t;

  // One row is a run of packet bytes; lst closes the packet.
  typedef struct packed {
    logic [7:0]  value;
    logic [11:0] count;
    logic        rnd;
    logic        cookie;
    logic        lst;
    logic        chk;
    logic [2:0]  st;
  } seg_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  kind_o;
  logic [3:0]  field_id_o;
  logic [31:0] field_value_o;
  logic [7:0]  option_code_o;
  logic [7:0]  byte_offset_o;
  logic [2:0]  status_o;
  logic        last_result_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [31:0] cfg_data_i = 32'd0;

  dhcp_packet_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .field_id_o    (field_id_o),
    .field_value_o (field_value_o),
    .option_code_o (option_code_o),
    .byte_offset_o (byte_offset_o),
    .status_o      (status_o),
    .last_result_o (last_result_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Register copies and parser state of the predictor
  logic [10:0] min_len_cfg;
  logic [31:0] cookie_cfg;
  logic [10:0] pkt_len;
  phase_e      pkt_phase;
  logic [31:0] hdr_acc;
  logic [3:0]  hdr_id;
  logic [10:0] fld_start;
  logic [7:0]  cur_code;
  logic [7:0]  opt_left;
  logic [7:0]  opt_off;
  logic        cookie_mismatch;

  parse_result_t pending_results [$];
  logic [7:0]    pkt_bytes [$];

  int unsigned err_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned packets_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned cycle_count = 0;
  int unsigned status_tally [5] = '{default: 0};
  bit          hold_rx = 1'b0;

  seg_t seg_tab [NumSegs] = '{
    '{8'hFF,    12'd1,    1'b0, 1'b0, 1'b1, 1'b1, StTooShort},
    '{8'hFF,    12'd236,  1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd4,    1'b0, 1'b1, 1'b0, 1'b0, StOk},
    '{OptPad,   12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h35,    12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h01,    12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'hFF,    12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{OptEnd,   12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd1,    1'b0, 1'b0, 1'b1, 1'b1, StOk},
    '{8'h00,    12'd236,  1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd4,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h01,    12'd3,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h02,    12'd1,    1'b0, 1'b0, 1'b1, 1'b1, StBadCookie},
    '{8'h00,    12'd236,  1'b1, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd4,    1'b0, 1'b1, 1'b0, 1'b0, StOk},
    '{8'h01,    12'd1,    1'b0, 1'b0, 1'b1, 1'b1, StNoLength},
    '{8'h00,    12'd236,  1'b1, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd4,    1'b0, 1'b1, 1'b0, 1'b0, StOk},
    '{8'hFE,    12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'hFF,    12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd3,    1'b1, 1'b0, 1'b1, 1'b1, StTruncated},
    '{8'h00,    12'd236,  1'b1, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd4,    1'b0, 1'b1, 1'b0, 1'b0, StOk},
    '{8'h07,    12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd1,    1'b0, 1'b0, 1'b1, 1'b1, StOk},
    '{8'h00,    12'd236,  1'b1, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd4,    1'b0, 1'b1, 1'b0, 1'b0, StOk},
    '{8'h2B,    12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'hFF,    12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd255,  1'b1, 1'b0, 1'b0, 1'b0, StOk},
    '{OptEnd,   12'd1,    1'b0, 1'b0, 1'b1, 1'b1, StOk},
    '{8'h00,    12'd236,  1'b1, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd4,    1'b0, 1'b1, 1'b1, 1'b1, StOk},
    '{8'h00,    12'd239,  1'b1, 1'b0, 1'b1, 1'b1, StTooShort},
    '{8'h00,    12'd236,  1'b1, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd4,    1'b0, 1'b1, 1'b0, 1'b0, StOk},
    '{OptPad,   12'd1900, 1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h0C,    12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h02,    12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd2,    1'b1, 1'b0, 1'b0, 1'b0, StOk},
    '{OptPad,   12'd10,   1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{OptEnd,   12'd1,    1'b0, 1'b0, 1'b0, 1'b0, StOk},
    '{8'h00,    12'd3,    1'b1, 1'b0, 1'b1, 1'b1, StOk}
  };

  function automatic parse_result_t make_result(input logic [2:0] kind,
                                                input logic [3:0] id,
                                                input logic [31:0] val,
                                                input logic [7:0] code,
                                                input logic [7:0] off,
                                                input logic [2:0] st);
    return '{kind, id, val, code, off, st, 1'b0};
  endfunction

  function automatic bit closes_field(input logic [10:0] p);
    return (p <= 11'd3) || (p == 11'd7) || (p == 11'd9) || (p == 11'd11) ||
           (p == 11'd15) || (p == 11'd19) || (p == 11'd23) || (p == 11'd27);
  endfunction

  function automatic int unsigned pick_gap(input int unsigned mode);
    case (mode)
      GapNone: return 0;
      GapAny:  return $urandom_range(0, 16);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  task automatic start_packet();
    pkt_len         = '0;
    pkt_phase       = PH_FIXED;
    hdr_acc         = '0;
    hdr_id          = '0;
    fld_start       = '0;
    cur_code        = '0;
    opt_left        = '0;
    opt_off         = '0;
    cookie_mismatch = 1'b0;
  endtask

  // Predict the results of one accepted packet byte.
  task automatic parse_byte(input logic [7:0] b, input logic lb);
    parse_result_t outs [2];
    parse_result_t r;
    int            n;
    logic [10:0]   pos;
    int unsigned   w;
    logic [31:0]   mask;
    logic [2:0]    st;
    n   = 0;
    pos = pkt_len;
    if (pkt_len != MaxPacketBytes) pkt_len = pkt_len + 11'd1;
    case (pkt_phase)
      PH_FIXED: begin
        hdr_acc = {hdr_acc[23:0], b};
        if (pos < ChaddrAt) begin
          if (closes_field(pos)) begin
            w    = pos + 1 - fld_start;
            mask = (w >= 4) ? 32'hFFFF_FFFF : (32'd1 << (8 * w)) - 32'd1;
            outs[n++] = make_result(KindField, hdr_id, hdr_acc & mask, 8'd0, 8'd0, StOk);
            hdr_id    = hdr_id + 4'd1;
            fld_start = pos + 11'd1;
          end
        end else if (pos < SnameAt) begin
          outs[n++] = make_result(KindAreaByte, IdChaddr, {24'd0, b}, 8'd0,
                                  8'(pos - ChaddrAt), StOk);
        end else if (pos < FileAt) begin
          outs[n++] = make_result(KindAreaByte, IdSname, {24'd0, b}, 8'd0,
                                  8'(pos - SnameAt), StOk);
        end else if (pos < AreaEnd) begin
          outs[n++] = make_result(KindAreaByte, IdFile, {24'd0, b}, 8'd0,
                                  8'(pos - FileAt), StOk);
        end else if (pos == CookieLast) begin
          if (hdr_acc != cookie_cfg) begin
            cookie_mismatch = 1'b1;
            pkt_phase       = PH_DONE;
          end else begin
            pkt_phase = PH_CODE;
          end
        end
      end
      PH_CODE: begin
        if (b == OptEnd) begin
          pkt_phase = PH_DONE;
        end else if (b != OptPad) begin
          cur_code  = b;
          pkt_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        outs[n++] = make_result(KindOptHdr, 4'd0, {24'd0, b}, cur_code, 8'd0, StOk);
        opt_left  = b;
        opt_off   = 8'd0;
        pkt_phase = (b == 8'd0) ? PH_CODE : PH_VALUE;
      end
      PH_VALUE: begin
        outs[n++] = make_result(KindOptByte, 4'd0, {24'd0, b}, cur_code, opt_off, StOk);
        opt_off  = opt_off + 8'd1;
        opt_left = opt_left - 8'd1;
        if (opt_left == 8'd0) pkt_phase = PH_CODE;
      end
      default: ;
    endcase
    if (lb) begin
      if (pkt_len < CookieEnd || pkt_len < min_len_cfg) st = StTooShort;
      else if (cookie_mismatch) st = StBadCookie;
      else if (pkt_phase == PH_LEN) st = StNoLength;
      else if (pkt_phase == PH_VALUE && opt_left != 8'd0) st = StTruncated;
      else st = StOk;
      outs[n++] = make_result(KindStatus, 4'd0, 32'd0, 8'd0, 8'd0, st);
      start_packet();
    end
    for (int i = 0; i < n; i++) begin
      r = outs[i];
      r.last_result = (i == n - 1);
      pending_results.insert(pending_results.size(), r);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lb, input int unsigned gap);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= lb;
    do @(posedge clk_i); while (full);
    parse_byte(b, lb);
    bytes_sent++;
  endtask

  task automatic send_packet(input bit typed, input logic [2:0] typed_st, input int pause_at);
    int unsigned mode;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      if (i == pause_at) begin
        push <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, pick_gap(mode));
    end
    if (typed) pending_results[pending_results.size() - 1].status = typed_st;
    push <= 1'b0;
    @(posedge clk_i);
    packets_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (IdleSettle) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgMinLen: min_len_cfg = val[10:0];
      CfgCookie: cookie_cfg = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Mostly well-formed packets with random content; some noise packets of 1 to 300 bytes.
  task automatic build_random_packet();
    int unsigned sel, n, len, target, tail;
    logic [31:0] ck;
    pkt_bytes.delete();
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      n = $urandom_range(1, 300);
      repeat (n) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
    end else begin
      repeat (236) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
      ck = ($urandom_range(0, 9) != 0) ? cookie_cfg : $urandom;
      for (int k = 0; k < 4; k++) pkt_bytes.insert(pkt_bytes.size(), ck[31 - 8 * k -: 8]);
      n = $urandom_range(0, 5);
      repeat (n) begin
        if ($urandom_range(0, 5) == 0) begin
          pkt_bytes.insert(pkt_bytes.size(), OptPad);
        end else begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
          pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(1, 254)));
          pkt_bytes.insert(pkt_bytes.size(), 8'(len));
          repeat (len) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        target = $urandom_range(240, 1100);
        while (pkt_bytes.size() < target) pkt_bytes.insert(pkt_bytes.size(), OptPad);
      end
      tail = $urandom_range(0, 9);
      if (tail < 6) begin
        pkt_bytes.insert(pkt_bytes.size(), OptEnd);
        repeat ($urandom_range(0, 5)) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
      end else if (tail == 6) begin
        pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(1, 254)));
      end else if (tail == 7) begin
        len = $urandom_range(2, 40);
        pkt_bytes.insert(pkt_bytes.size(), 8'($urandom_range(1, 254)));
        pkt_bytes.insert(pkt_bytes.size(), 8'(len));
        repeat ($urandom_range(0, len - 1)) pkt_bytes.insert(pkt_bytes.size(), 8'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: pop with random idling and check each transaction.
  initial begin
    parse_result_t act, exp;
    int unsigned   gap, rx_mode;
    rx_mode = GapAny;
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      gap = pick_gap(rx_mode);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      act = '{kind_o, field_id_o, field_value_o, option_code_o, byte_offset_o,
              status_o, last_result_o};
      results_seen++;
      if (results_seen % 64 == 0) rx_mode = $urandom_range(0, 2);
      if (act.kind == KindStatus && act.status <= StTruncated) status_tally[act.status]++;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("result %0d: none expected, got kind=%0d id=%0d value=%h code=%h",
                   results_seen, act.kind, act.field_id, act.field_value, act.option_code);
      end else begin
        exp = pending_results.pop_front();
        if (act !== exp) begin
          err_count++;
          if (err_count <= MaxReports) begin
            $display("result %0d: expected kind=%0d id=%0d value=%h code=%h off=%0d st=%0d last=%0d",
                     results_seen, exp.kind, exp.field_id, exp.field_value, exp.option_code,
                     exp.byte_offset, exp.status, exp.last_result);
            $display("result %0d: got      kind=%0d id=%0d value=%h code=%h off=%0d st=%0d last=%0d",
                     results_seen, act.kind, act.field_id, act.field_value, act.option_code,
                     act.byte_offset, act.status, act.last_result);
          end
        end
      end
    end
  end

  initial begin
    int unsigned cfg_step, choice, rand_start, rand_pkts;
    min_len_cfg = MinLenReset;
    cookie_cfg  = CookieReset;
    start_packet();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (IdleSettle) @(posedge clk_i);

    foreach (seg_tab[s]) begin
      if (seg_tab[s].cookie) begin
        for (int k = 0; k < 4; k++)
          pkt_bytes.insert(pkt_bytes.size(), cookie_cfg[31 - 8 * k -: 8]);
      end else begin
        repeat (seg_tab[s].count)
          pkt_bytes.insert(pkt_bytes.size(),
                           seg_tab[s].rnd ? 8'($urandom) : seg_tab[s].value);
      end
      if (seg_tab[s].lst) begin
        send_packet(seg_tab[s].chk, seg_tab[s].st, -1);
        pkt_bytes.delete();
      end
    end

    cfg_step   = 0;
    rand_pkts  = 0;
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RandItems) begin
      if (cfg_step < 11 || $urandom_range(0, 2) == 0) begin
        choice = (cfg_step < 11) ? cfg_step : $urandom_range(0, 10);
        case (choice)
          0:  write_reg(CfgMinLen, 32'd0);
          1:  write_reg(CfgCookie, 32'd0);
          2:  write_reg(CfgMinLen, 32'd1024);
          3:  write_reg(CfgCookie, 32'hFFFF_FFFF);
          4:  write_reg(CfgSpare, $urandom);
          5:  write_reg(CfgMinLen, 32'($urandom_range(240, 1024)));
          6:  write_reg(CfgCookie, $urandom);
          7:  write_reg(CfgMinLen, 32'd2047);
          8:  write_reg(CfgMinLen, 32'(MinLenReset));
          9:  write_reg(CfgCookie, CookieReset);
          default: write_reg(CfgMinLen, 32'($urandom_range(0, 2047)));
        endcase
        cfg_step++;
      end
      build_random_packet();
      if (rand_pkts == 0) hold_rx = 1'b1;
      send_packet(1'b0, StOk, (rand_pkts == 1) ? pkt_bytes.size() / 2 : -1);
      rand_pkts++;
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d packets (%0d bytes), checked %0d results, %0d register writes",
             packets_sent, bytes_sent, results_seen, cfg_writes);
    $display("Final status seen: ok %0d, short %0d, cookie %0d, no length %0d, truncated %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
